// File: src/gmtu_pkg.sv
// shared types and constants for the gap material trial update block
`timescale 1ns / 1ps

package gmtu_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int DIV_STEPS = 59;
   localparam int MUL_STEPS = 32;

   localparam logic [30:0] RESET_MODULUS = 31'd256;
   localparam logic [30:0] RESET_YIELD = 31'd256;
   localparam logic [30:0] RESET_GAP = 31'd0;

   localparam logic [1:0] CSR_MODULUS = 2'd0;
   localparam logic [1:0] CSR_YIELD = 2'd1;
   localparam logic [1:0] CSR_GAP = 2'd2;

   localparam logic [1:0] DIR_NONE = 2'd0;
   localparam logic [1:0] DIR_LOAD = 2'd1;
   localparam logic [1:0] DIR_UNLOAD = 2'd2;

   typedef enum logic [1:0] {
      CMD_UPDATE = 2'd0,
      CMD_COMMIT = 2'd1,
      CMD_REVERT = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_DONE
   } state_type;

   typedef struct packed {
      cmd_type cmd;
      logic [31:0] strain;
   } item_type;

   typedef struct packed {
      logic valid;
      item_type item;
   } queue_out_type;

   // saturate a wide two's complement value to 32 bits
   function automatic logic [31:0] sat32(input logic [60:0] v);
      logic [31:0] r;
      if (v[60:31] == '0 || v[60:31] == '1) begin
         r = v[31:0];
      end else if (v[60]) begin
         r = 32'h8000_0000;
      end else begin
         r = 32'h7FFF_FFFF;
      end
      return r;
   endfunction

endpackage

// File: src/gmtu_front.sv
// front end: accepts commands, decodes them and queues them for the back end
`timescale 1ns / 1ps

module gmtu_front #(
   parameter int QueueDepth = gmtu_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_command,
   input  logic [31:0]             req_strain_in,
   output gmtu_pkg::queue_out_type q_out,
   input  logic                    q_pop
);

   localparam int PtrW = $clog2(QueueDepth);
   localparam int CntW = $clog2(QueueDepth + 1);

   gmtu_pkg::item_type mem_ff [QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic push;
   gmtu_pkg::item_type item;

   assign req_stall = (count_ff == CntW'(QueueDepth));
   assign push = req_valid && !req_stall;

   always_comb begin
      item.cmd = gmtu_pkg::cmd_type'(req_command);
      item.strain = req_strain_in;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= item;
      end
   end

   assign q_out.valid = (count_ff != '0);
   assign q_out.item = mem_ff[rd_ptr_ff];

endmodule

// File: src/gmtu_back.sv
// back end: material state, iterative divider and multiplier, result register
`timescale 1ns / 1ps

module gmtu_back (
   input  logic                    clock,
   input  logic                    reset,
   input  gmtu_pkg::queue_out_type q_out,
   output logic                    q_pop,
   input  logic [30:0]             modulus,
   input  logic [30:0]             yield_level,
   input  logic [30:0]             gap_size,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [30:0]             rsp_stress_out,
   output logic [30:0]             rsp_tangent_out,
   output logic                    rsp_clamped
);

   gmtu_pkg::state_type state_ff, state_in;

   logic [31:0] c_strain_ff, c_strain_in, c_res_ff, c_res_in;
   logic [30:0] c_stress_ff, c_stress_in;
   logic        c_stiff_ff, c_stiff_in;
   logic [1:0]  c_dir_ff, c_dir_in;
   logic [31:0] p_strain_ff, p_strain_in, p_res_ff, p_res_in;
   logic [30:0] p_stress_ff, p_stress_in;
   logic        p_stiff_ff, p_stiff_in;
   logic [1:0]  p_dir_ff, p_dir_in;

   logic [5:0]  cnt_ff, cnt_in;
   logic [30:0] rem_ff, rem_in;
   logic [58:0] quo_ff, quo_in;
   logic [31:0] inc_ff, inc_in;
   logic [62:0] mcand_ff, mcand_in;
   logic [63:0] acc_ff, acc_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [30:0] rsp_stress_ff, rsp_stress_in, rsp_tangent_ff, rsp_tangent_in;
   logic        rsp_clamped_ff, rsp_clamped_in;

   logic        take, load_rsp, div_last, mul_last;
   logic [32:0] inc_full;
   logic [33:0] gap_inc;
   logic        inc_zero, inc_pos, unload_case;
   logic [30:0] divisor;
   logic [31:0] rem_sh;
   logic        q_bit;
   logic [58:0] quo_next;
   logic [60:0] res_wide;
   logic [35:0] prod;
   logic [36:0] s_wide;

   assign take = q_out.valid && !rsp_valid_ff && (state_ff == gmtu_pkg::ST_IDLE);
   assign div_last = (cnt_ff == 6'(gmtu_pkg::DIV_STEPS - 1));
   assign mul_last = (cnt_ff == 6'(gmtu_pkg::MUL_STEPS - 1));

   assign inc_full = {q_out.item.strain[31], q_out.item.strain} - {c_strain_ff[31], c_strain_ff};
   assign gap_inc = {{2{q_out.item.strain[31]}}, q_out.item.strain} - {3'b0, gap_size}
                    - {{2{c_res_ff[31]}}, c_res_ff};
   assign inc_zero = (inc_full == '0);
   assign inc_pos = !inc_full[32] && !inc_zero;
   assign unload_case = inc_full[32] && (c_dir_ff == gmtu_pkg::DIR_LOAD) && (c_stress_ff != '0);

   assign divisor = (modulus == '0) ? 31'd1 : modulus;
   assign rem_sh = {rem_ff, quo_ff[58]};
   assign q_bit = (rem_sh >= {1'b0, divisor});
   assign quo_next = {quo_ff[57:0], q_bit};
   assign res_wide = {{29{c_strain_ff[31]}}, c_strain_ff} - {2'b0, quo_next}
                     - {30'b0, gap_size};

   // floor of the q.36 product down to q28.8 is an arithmetic shift
   assign prod = acc_ff[63:28];
   assign s_wide = {6'b0, c_stress_ff} + {prod[35], prod};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gmtu_pkg::ST_IDLE: begin
            if (take && (q_out.item.cmd == gmtu_pkg::CMD_UPDATE) && !inc_zero) begin
               state_in = unload_case ? gmtu_pkg::ST_DIV : gmtu_pkg::ST_MUL;
            end
         end
         gmtu_pkg::ST_DIV: begin
            if (div_last) begin
               state_in = gmtu_pkg::ST_MUL;
            end
         end
         gmtu_pkg::ST_MUL: begin
            if (mul_last) begin
               state_in = gmtu_pkg::ST_DONE;
            end
         end
         gmtu_pkg::ST_DONE: state_in = gmtu_pkg::ST_IDLE;
         default: state_in = gmtu_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      q_pop = 1'b0;
      load_rsp = 1'b0;
      c_strain_in = c_strain_ff;
      c_stress_in = c_stress_ff;
      c_stiff_in = c_stiff_ff;
      c_res_in = c_res_ff;
      c_dir_in = c_dir_ff;
      p_strain_in = p_strain_ff;
      p_stress_in = p_stress_ff;
      p_stiff_in = p_stiff_ff;
      p_res_in = p_res_ff;
      p_dir_in = p_dir_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      inc_in = inc_ff;
      mcand_in = mcand_ff;
      acc_in = acc_ff;
      case (state_ff)
         gmtu_pkg::ST_IDLE: begin
            if (take) begin
               q_pop = 1'b1;
               case (q_out.item.cmd)
                  gmtu_pkg::CMD_UPDATE: begin
                     p_strain_in = q_out.item.strain;
                     if (inc_zero) begin
                        load_rsp = 1'b1;
                     end else begin
                        p_res_in = c_res_ff;
                        p_dir_in = inc_pos ? gmtu_pkg::DIR_LOAD : gmtu_pkg::DIR_UNLOAD;
                        if (inc_pos && (c_stress_ff == '0)) begin
                           inc_in = gmtu_pkg::sat32({{27{gap_inc[33]}}, gap_inc});
                        end else begin
                           inc_in = gmtu_pkg::sat32({{28{inc_full[32]}}, inc_full});
                        end
                        cnt_in = '0;
                        rem_in = '0;
                        quo_in = {c_stress_ff, 28'b0};
                        mcand_in = {32'b0, modulus};
                        acc_in = '0;
                     end
                  end
                  gmtu_pkg::CMD_COMMIT: begin
                     load_rsp = 1'b1;
                     c_strain_in = p_strain_ff;
                     c_stress_in = p_stress_ff;
                     c_stiff_in = p_stiff_ff;
                     c_res_in = p_res_ff;
                     c_dir_in = p_dir_ff;
                  end
                  gmtu_pkg::CMD_REVERT: begin
                     load_rsp = 1'b1;
                     p_strain_in = c_strain_ff;
                     p_stress_in = c_stress_ff;
                     p_stiff_in = c_stiff_ff;
                     p_res_in = c_res_ff;
                     p_dir_in = c_dir_ff;
                  end
                  gmtu_pkg::CMD_CLEAR: begin
                     load_rsp = 1'b1;
                     c_strain_in = '0;
                     c_stress_in = '0;
                     c_stiff_in = 1'b1;
                     c_res_in = '0;
                     c_dir_in = gmtu_pkg::DIR_NONE;
                     p_strain_in = '0;
                     p_stress_in = '0;
                     p_stiff_in = 1'b1;
                     p_res_in = '0;
                     p_dir_in = gmtu_pkg::DIR_NONE;
                  end
                  default: load_rsp = 1'b1;
               endcase
            end
         end
         gmtu_pkg::ST_DIV: begin
            // restoring division, one quotient bit a cycle
            rem_in = q_bit ? 31'(rem_sh - {1'b0, divisor}) : rem_sh[30:0];
            quo_in = quo_next;
            cnt_in = div_last ? '0 : cnt_ff + 1'b1;
            if (div_last) begin
               p_res_in = gmtu_pkg::sat32(res_wide);
            end
         end
         gmtu_pkg::ST_MUL: begin
            // shift and add; the top bit of the increment carries negative weight
            if (inc_ff[0]) begin
               acc_in = mul_last ? acc_ff - {1'b0, mcand_ff} : acc_ff + {1'b0, mcand_ff};
            end
            inc_in = {1'b0, inc_ff[31:1]};
            mcand_in = {mcand_ff[61:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
         end
         gmtu_pkg::ST_DONE: begin
            load_rsp = 1'b1;
            if (s_wide[36]) begin
               p_stress_in = '0;
               p_stiff_in = 1'b0;
            end else if (s_wide[35:0] > {5'b0, yield_level}) begin
               p_stress_in = yield_level;
               p_stiff_in = 1'b0;
            end else begin
               p_stress_in = s_wide[30:0];
               p_stiff_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end
      rsp_stress_in = p_stress_in;
      rsp_tangent_in = p_stiff_in ? modulus : '0;
      rsp_clamped_in = !p_stiff_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gmtu_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         c_strain_ff <= '0;
         c_stress_ff <= '0;
         c_stiff_ff <= 1'b1;
         c_res_ff <= '0;
         c_dir_ff <= gmtu_pkg::DIR_NONE;
         p_strain_ff <= '0;
         p_stress_ff <= '0;
         p_stiff_ff <= 1'b1;
         p_res_ff <= '0;
         p_dir_ff <= gmtu_pkg::DIR_NONE;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         c_strain_ff <= c_strain_in;
         c_stress_ff <= c_stress_in;
         c_stiff_ff <= c_stiff_in;
         c_res_ff <= c_res_in;
         c_dir_ff <= c_dir_in;
         p_strain_ff <= p_strain_in;
         p_stress_ff <= p_stress_in;
         p_stiff_ff <= p_stiff_in;
         p_res_ff <= p_res_in;
         p_dir_ff <= p_dir_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      inc_ff <= inc_in;
      mcand_ff <= mcand_in;
      acc_ff <= acc_in;
      if (load_rsp) begin
         rsp_stress_ff <= rsp_stress_in;
         rsp_tangent_ff <= rsp_tangent_in;
         rsp_clamped_ff <= rsp_clamped_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_stress_out = rsp_stress_ff;
   assign rsp_tangent_out = rsp_tangent_ff;
   assign rsp_clamped = rsp_clamped_ff;

`ifndef ASSERT_OFF
   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff != gmtu_pkg::ST_IDLE) |-> !rsp_valid_ff)
      else $error("back end busy while a result is held");
   a_pop_progress: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (state_ff != gmtu_pkg::ST_IDLE) || rsp_valid_ff)
      else $error("popped command neither running nor answered");
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gmtu_pkg::ST_DIV) |-> (cnt_ff < 6'(gmtu_pkg::DIV_STEPS)))
      else $error("divider step count overrun");
   a_dir_valid: assert property (@(posedge clock) disable iff (reset)
      (c_dir_ff == gmtu_pkg::DIR_NONE || c_dir_ff == gmtu_pkg::DIR_LOAD ||
       c_dir_ff == gmtu_pkg::DIR_UNLOAD) &&
      (p_dir_ff == gmtu_pkg::DIR_NONE || p_dir_ff == gmtu_pkg::DIR_LOAD ||
       p_dir_ff == gmtu_pkg::DIR_UNLOAD))
      else $error("load direction code not produced by any command");
`endif

endmodule

// File: src/gap_material_trial_update_top.sv
// top level of the gap material trial update block
`timescale 1ns / 1ps

// One-dimensional gap material point with trial and committed state. Commands
// go into a short queue and are carried out one at a time by the back end;
// the result of each transfer is held in an output register while the next
// commands queue up. Commit, revert, clear and an update with zero increment
// are answered directly from the idle state. Any other update runs the 32-step
// shift-and-add multiplier between setup and clamp; an unload after loading
// with nonzero stress first runs the 59-step restoring divider.

module gap_material_trial_update_top #(
   parameter int QueueDepth = gmtu_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_strain_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [30:0] rsp_stress_out,
   output logic [30:0] rsp_tangent_out,
   output logic        rsp_clamped,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [30:0] csr_wdata
);

   gmtu_pkg::queue_out_type q_out;
   logic q_pop;
   logic [30:0] modulus_ff, modulus_in, yield_ff, yield_in, gap_ff, gap_in;

   always_comb begin
      modulus_in = modulus_ff;
      yield_in = yield_ff;
      gap_in = gap_ff;
      if (csr_write_en) begin
         case (csr_index)
            gmtu_pkg::CSR_MODULUS: modulus_in = csr_wdata;
            gmtu_pkg::CSR_YIELD: yield_in = csr_wdata;
            gmtu_pkg::CSR_GAP: gap_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= gmtu_pkg::RESET_MODULUS;
         yield_ff <= gmtu_pkg::RESET_YIELD;
         gap_ff <= gmtu_pkg::RESET_GAP;
      end else begin
         modulus_ff <= modulus_in;
         yield_ff <= yield_in;
         gap_ff <= gap_in;
      end
   end

   gmtu_front #(
      .QueueDepth(QueueDepth)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_strain_in(req_strain_in),
      .q_out(q_out),
      .q_pop(q_pop)
   );

   gmtu_back u_back (
      .clock(clock),
      .reset(reset),
      .q_out(q_out),
      .q_pop(q_pop),
      .modulus(modulus_ff),
      .yield_level(yield_ff),
      .gap_size(gap_ff),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_stress_out(rsp_stress_out),
      .rsp_tangent_out(rsp_tangent_out),
      .rsp_clamped(rsp_clamped)
   );

endmodule
